@@ src/double_sha256_nonce_check_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the nonce checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_SHA256_NONCE_CHECK_MACROS_SVH
`define DOUBLE_SHA256_NONCE_CHECK_MACROS_SVH
`ifndef SYNTHESIS
`define DSN_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define DSN_ASSERT_NR(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DSN_ASSERT(label, prop)
`define DSN_ASSERT_NR(label, prop)
`endif
`endif

@@ src/dsn_pkg.sv @@
// ----------------------------------------------------------------------------
// Nonce checker package
// Types, constants and round functions for the double hash pipeline.
// ----------------------------------------------------------------------------
package dsn_pkg;

    localparam int HeaderBytes = 512 / 8;
    localparam int HeaderRegs = HeaderBytes / 8;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;
    localparam int Rounds = 64;
    localparam logic [31:0] TailLenBits = 32'((HeaderBytes + 4) * 8);
    localparam logic [31:0] DigestLenBits = 32'd256;
    localparam logic [31:0] PadWord = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] nonce;
        logic [31:0] target;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] nonce_echo;
        logic [31:0] hash_word;
        logic        found;
    } out_beat_t;

    typedef logic [7:0][31:0] hstate_t;
    typedef logic [15:0][31:0] wwin_t;

    localparam hstate_t InitH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [63:0][31:0] RoundK = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // One compression round; s[0] is a, s[7] is h.
    function automatic hstate_t round_step(input hstate_t s, input logic [31:0] kw);
        logic [31:0] t1;
        logic [31:0] t2;
        hstate_t r;
        t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + kw;
        t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        r[7] = s[6];
        r[6] = s[5];
        r[5] = s[4];
        r[4] = s[3] + t1;
        r[3] = s[2];
        r[2] = s[1];
        r[1] = s[0];
        r[0] = t1 + t2;
        return r;
    endfunction

    // Slides the schedule window by one word.
    function automatic wwin_t sched_step(input wwin_t w);
        logic [31:0] s0;
        logic [31:0] s1;
        wwin_t r;
        s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
        s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        for (int i = 0; i < 15; i++)
        begin
            r[i] = w[i + 1];
        end
        r[15] = w[0] + s0 + w[9] + s1;
        return r;
    endfunction

endpackage

@@ src/dsn_compress.sv @@
// ----------------------------------------------------------------------------
// Pipelined compression
// Sixty-four registered rounds of one block compression with feed-forward.
// ----------------------------------------------------------------------------
module dsn_compress
    import dsn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        in_valid,
    input  hstate_t     in_h,
    input  wwin_t       in_w,
    input  in_beat_t    in_side,
    output logic        out_valid,
    output hstate_t     out_h,
    output in_beat_t    out_side
);

    logic [Rounds-1:0]        valid_reg;
    hstate_t                  st_reg [Rounds];
    hstate_t                  hin_reg [Rounds];
    wwin_t                    w_reg [Rounds];
    in_beat_t                 side_reg [Rounds];

    for (genvar r = 0; r < Rounds; r++)
    begin : g_round
        logic     valid_cur;
        hstate_t  st_cur;
        hstate_t  hin_cur;
        wwin_t    w_cur;
        in_beat_t side_cur;

        if (r == 0)
        begin : g_first
            assign valid_cur = in_valid;
            assign st_cur = in_h;
            assign hin_cur = in_h;
            assign w_cur = in_w;
            assign side_cur = in_side;
        end
        else
        begin : g_chain
            assign valid_cur = valid_reg[r - 1];
            assign st_cur = st_reg[r - 1];
            assign hin_cur = hin_reg[r - 1];
            assign w_cur = w_reg[r - 1];
            assign side_cur = side_reg[r - 1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[r] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[r] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[r] <= round_step(st_cur, RoundK[r] + w_cur[0]);
                hin_reg[r] <= hin_cur;
                w_reg[r] <= sched_step(w_cur);
                side_reg[r] <= side_cur;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            out_h[i] = hin_reg[Rounds - 1][i] + st_reg[Rounds - 1][i];
        end
    end

    assign out_valid = valid_reg[Rounds - 1];
    assign out_side = side_reg[Rounds - 1];

endmodule

@@ src/double_sha256_nonce_check.sv @@
// ----------------------------------------------------------------------------
// Double hash nonce checker
// Hashes header plus nonce twice and compares the first digest word.
// ----------------------------------------------------------------------------
// One nonce is accepted every cycle while the output is not held; each result
// passes through three chained 64-round compression pipelines plus an output
// register. The whole pipeline advances together; a stall at the output holds
// every stage. Header writes must be made while the pipeline is empty.
`include "double_sha256_nonce_check_macros.svh"
module double_sha256_nonce_check
    import dsn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_beat_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_beat_t           out_data,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    logic [HeaderRegs-1:0][CfgDataW-1:0] hdr_reg;
    logic        advance;
    logic        v1;
    logic        v2;
    logic        v3;
    hstate_t     h1;
    hstate_t     h2;
    hstate_t     h3;
    in_beat_t    s1;
    in_beat_t    s2;
    in_beat_t    s3;
    wwin_t       w_head;
    wwin_t       w_tail;
    wwin_t       w_dig;
    logic        out_valid_reg;
    out_beat_t   out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
        end
        else if (cfg_we)
        begin
            hdr_reg[cfg_index] <= cfg_data;
        end
    end

    assign advance = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_head[i] = (i % 2 == 1) ? hdr_reg[i / 2][31:0] : hdr_reg[i / 2][63:32];
        end
        w_tail = '0;
        w_tail[0] = {s1.nonce[7:0], s1.nonce[15:8], s1.nonce[23:16], s1.nonce[31:24]};
        w_tail[1] = PadWord;
        w_tail[15] = TailLenBits;
        w_dig = '0;
        for (int i = 0; i < 8; i++)
        begin
            w_dig[i] = h2[i];
        end
        w_dig[8] = PadWord;
        w_dig[15] = DigestLenBits;
    end

    dsn_compress u_head (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(in_valid), .in_h(InitH), .in_w(w_head), .in_side(in_data),
        .out_valid(v1), .out_h(h1), .out_side(s1)
    );

    dsn_compress u_tail (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(v1), .in_h(h1), .in_w(w_tail), .in_side(s1),
        .out_valid(v2), .out_h(h2), .out_side(s2)
    );

    dsn_compress u_dig (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .in_valid(v2), .in_h(InitH), .in_w(w_dig), .in_side(s2),
        .out_valid(v3), .out_h(h3), .out_side(s3)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.nonce_echo <= s3.nonce;
            out_data_reg.hash_word <= h3[0];
            out_data_reg.found <= (h3[0] <= s3.target);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    `DSN_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_data))
    `DSN_ASSERT(a_ready_when_free, !out_valid |-> in_ready)
    `DSN_ASSERT(a_out_known, out_valid |-> !$isunknown(out_data))
    `DSN_ASSERT_NR(a_reset_empty, $rose(rst_n) |-> !out_valid)

endmodule

@@ sim/double_sha256_nonce_check_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nonce checker testbench
// Drives nonce and target beats with random gaps, holds off the output at
// random and once for a long stretch, and checks every result against a
// double hash computed here from the header the testbench has written.
// ----------------------------------------------------------------------------
module double_sha256_nonce_check_tb;
    import dsn_pkg::*;

    localparam int LatencyCycles = 260;
    localparam int WatchdogLimit = 4000;

    typedef logic [31:0] word_t;

    class hash_scoreboard;
        logic [63:0] header[HeaderRegs];
        out_beat_t pending[$];
        int errors;

        function new();
            errors = 0;
            foreach (header[i])
            begin
                header[i] = '0;
            end
        endfunction

        function word_t ror(word_t x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress(ref word_t h[8], input word_t blk[16]);
            word_t w[64];
            word_t a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = blk[i];
            end
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            a = h[0]; b = h[1]; c = h[2]; d = h[3];
            e = h[4]; f = h[5]; g = h[6]; hh = h[7];
            for (int i = 0; i < 64; i++)
            begin
                t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                    + RoundK[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                hh = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
            h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        endfunction

        function word_t first_digest_word(word_t nonce);
            word_t h[8];
            word_t h2[8];
            word_t blk[16];
            for (int i = 0; i < 8; i++)
            begin
                h[i] = InitH[i];
                h2[i] = InitH[i];
            end
            for (int i = 0; i < 16; i++)
            begin
                blk[i] = (i % 2) ? header[i/2][31:0] : header[i/2][63:32];
            end
            compress(h, blk);
            for (int i = 0; i < 16; i++)
            begin
                blk[i] = '0;
            end
            blk[0] = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
            blk[1] = PadWord;
            blk[15] = TailLenBits;
            compress(h, blk);
            for (int i = 0; i < 16; i++)
            begin
                blk[i] = (i < 8) ? h[i] : '0;
            end
            blk[8] = PadWord;
            blk[15] = DigestLenBits;
            compress(h2, blk);
            return h2[0];
        endfunction

        function void note_nonce(in_beat_t beat);
            out_beat_t r;
            r.nonce_echo = beat.nonce;
            r.hash_word = first_digest_word(beat.nonce);
            r.found = (r.hash_word <= beat.target);
            pending.push_back(r);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result nonce_echo %h", got.nonce_echo);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.nonce_echo !== exp.nonce_echo)
            begin
                $error("nonce_echo expected %h actual %h", exp.nonce_echo, got.nonce_echo);
                errors++;
            end
            if (got.hash_word !== exp.hash_word)
            begin
                $error("hash_word expected %h actual %h", exp.hash_word, got.hash_word);
                errors++;
            end
            if (got.found !== exp.found)
            begin
                $error("found expected %b actual %b", exp.found, got.found);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    hash_scoreboard board = new();
    bit long_hold = 1'b0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    double_sha256_nonce_check dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            board.note_nonce(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            board.check_result(out_data);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic write_header(int idx, logic [63:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx[CfgIdxW-1:0];
        cfg_data <= value;
        board.header[idx] = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_nonce(word_t nonce, word_t target, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= '{nonce: nonce, target: target};
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LatencyCycles) @(negedge clk);
    endtask

    initial
    begin
        word_t edge_vals[4];
        int mode;
        edge_vals = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (edge_vals[i])
        begin
            send_nonce(edge_vals[i], 32'h0, 1'b0);
            send_nonce(edge_vals[i], 32'hffff_ffff, 1'b0);
        end
        drain();
        for (int i = 0; i < HeaderRegs; i++)
        begin
            write_header(i, 64'hffff_ffff_ffff_ffff);
        end
        foreach (edge_vals[i])
        begin
            send_nonce(edge_vals[i], edge_vals[3 - i], 1'b0);
        end
        send_nonce(32'h1234_5678, 32'h0000_ffff, 1'b0);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            for (int i = 0; i < HeaderRegs; i++)
            begin
                mode = $urandom_range(0, 3);
                write_header(i, mode == 0 ? 64'h0 :
                    mode == 1 ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom});
            end
            if (phase == 2)
            begin
                long_hold = 1'b1;
            end
            for (int n = 0; n < 305; n++)
            begin
                mode = $urandom_range(0, 7);
                send_nonce($urandom,
                    mode == 0 ? 32'h0 : mode == 1 ? 32'hffff_ffff :
                    mode < 5 ? $urandom_range(0, 32'h0fff_ffff) : $urandom,
                    phase == 2 && n < 300 && $urandom_range(0, 3) != 0);
            end
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
